// ===== hdl/pm_pkg.sv =====
// ----------------------------------------------------------------------------
// pm_pkg
// Shared types, register indexes, state codes and the exp2 factor table
// of the possibilistic membership block.
// ----------------------------------------------------------------------------
package pm_pkg;

	localparam int CLASSES_DEF     = 4;
	localparam int SAMPLE_BITS_DEF = 16;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CLASSES_IN_USE = 2'd0;
	localparam logic [1:0] CFG_FUZZ_MODE      = 2'd1;
	localparam logic [1:0] CFG_INV_EXPONENT   = 2'd2;

	// Fuzzifier modes; any other code selects the general exponent.
	localparam logic [1:0] MODE_FUZZ_TWO     = 2'd0;
	localparam logic [1:0] MODE_FUZZ_ONEHALF = 2'd1;

	// Item opcodes.
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	typedef struct packed {
		logic        op;
		logic [1:0]  class_index;
		logic [15:0] pixel_ch0;
		logic [15:0] pixel_ch1;
		logic [15:0] center_ch0;
		logic [15:0] center_ch1;
		logic [31:0] eta_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_class;
		logic [15:0] membership;
		logic        last_class;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_READ,
		ST_SQA,
		ST_SQB,
		ST_DIVR_SET,
		ST_DIVR,
		ST_POW,
		ST_SQR,
		ST_SQR_RND,
		ST_NORM,
		ST_LOG,
		ST_LMUL,
		ST_EABS,
		ST_EDEC,
		ST_EXP,
		ST_ESHIFT,
		ST_DEN,
		ST_DIVU,
		ST_EMIT
	} state_t;

	// Truncated integer square root; evaluated at elaboration only.
	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = '0;
		b   = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 64'd0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Entry j holds 2^(2^-(16-j)) in Q2.30, built as a chain of square roots.
	function automatic logic [15:0][31:0] exp_table();
		logic [63:0]       t;
		logic [15:0][31:0] r;
		t = 64'd1 << 31;
		for (int i = 1; i <= 16; i++) begin
			t = isqrt64(t << 30);
			r[16 - i] = t[31:0];
		end
		return r;
	endfunction

	localparam logic [15:0][31:0] EXP_TAB = exp_table();

endpackage

// ===== hdl/possibilistic_membership.sv =====
// ----------------------------------------------------------------------------
// possibilistic_membership
// Per-class possibilistic membership u = 1/(1+r^k) of a two-channel pixel.
// ----------------------------------------------------------------------------
// Sequence: a pixel gives one result per class in use; a class runs read, squares, divide
//   setup, ratio divide (skipped when the ratio saturates), power, membership divide setup,
//   divide and emit, plus any wait for the result register. Power alone serves fuzzifier two
//   or a zero ratio; one and a half adds square and round; else normalize, log, multiply,
//   sign, decode, exp and shift (exp, shift skipped out of range). One item in work at a time.
// Reset (arst_n low, asynchronous): registers 4, 0, 4096; table reads as center 0, eta 1.
// ----------------------------------------------------------------------------
module possibilistic_membership #(
	parameter int CLASSES     = pm_pkg::CLASSES_DEF,
	parameter int SAMPLE_BITS = pm_pkg::SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Item channel: loads and pixels.
	input  logic         req_valid,
	output logic         req_ready,
	input  pm_pkg::req_t req,
	// Result channel: one transfer per class of a pixel.
	output logic         rsp_valid,
	input  logic         rsp_ready,
	output pm_pkg::rsp_t rsp,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import pm_pkg::*;

	localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int SB = SAMPLE_BITS;
	localparam int EW = 2 * SB + 32;   // table entry: {eta, center ch1, center ch0}

	// Configuration registers.
	logic [2:0]  classes_in_use_q;
	logic [1:0]  fuzz_mode_q;
	logic [15:0] inv_exponent_q;

	// Sequencer state.
	state_t state_q, state_d;

	// Class table. Entries that were never loaded read as the reset value,
	// tracked by one valid flag per entry.
	logic [EW-1:0]      mem [CLASSES];
	logic [CLASSES-1:0] vld_q;
	logic [EW-1:0]      rd_q;
	logic               rd_vld_q;

	// Per-pixel registers.
	logic [CW-1:0] cls_q;
	logic [CW-1:0] last_idx_q;
	logic [SB-1:0] px0_q, px1_q;

	// Datapath registers.
	logic [2*SB-1:0]     a2_q;
	logic [2*SB:0]       d2_q;
	logic [31:0]         r_q;
	logic [31:0]         s_q;
	logic [63:0]         mul_q;
	logic [31:0]         nrm_q;
	logic [4:0]          p_q;
	logic [30:0]         x_q;
	logic [15:0]         frac_q;
	logic signed [38:0]  t_q;
	logic [26:0]         q_q;
	logic                neg_q;
	logic signed [6:0]   n_q;
	logic [15:0]         f_q;
	logic [31:0]         m_q;
	logic [4:0]          itc_q;

	// Shared restoring divider.
	logic [32:0] rem_q;
	logic [32:0] dvs_q;
	logic [31:0] dvd_q;
	logic [31:0] qt_q;

	// Output register.
	logic out_vld_q;
	rsp_t out_q;

	logic req_xfer;
	logic out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;
	assign out_free  = !out_vld_q || rsp_ready;

	// ---------------------------------------------------------------------
	// Combinational helpers.
	// ---------------------------------------------------------------------
	logic [SB-1:0]        cen0, cen1;
	logic [31:0]          eta_raw, eta_eff;
	logic signed [SB:0]   dif_a, dif_b;
	logic signed [2*SB+1:0] sq_a, sq_b;

	assign cen0    = rd_vld_q ? rd_q[SB-1:0]    : '0;
	assign cen1    = rd_vld_q ? rd_q[2*SB-1:SB] : '0;
	assign eta_raw = rd_vld_q ? rd_q[EW-1:2*SB] : 32'd1;
	assign eta_eff = (eta_raw == 32'd0) ? 32'd1 : eta_raw;
	assign dif_a   = $signed({1'b0, px0_q}) - $signed({1'b0, cen0});
	assign dif_b   = $signed({1'b0, px1_q}) - $signed({1'b0, cen1});
	assign sq_a    = dif_a * dif_a;
	assign sq_b    = dif_b * dif_b;

	// Saturation test of the distance ratio: the quotient overflows 32 bits
	// exactly when d2 reaches eta scaled by 2^16.
	logic r_sat;
	assign r_sat = {15'd0, d2_q} >= {eta_eff, 16'd0};

	// Divider step.
	logic [33:0] div_trial;
	logic        div_ge;
	logic [32:0] div_rem;
	assign div_trial = {rem_q, dvd_q[31]};
	assign div_ge    = div_trial >= {1'b0, dvs_q};
	assign div_rem   = div_ge ? 33'(div_trial - {1'b0, dvs_q}) : div_trial[32:0];

	// Log2 squaring step on the normalized mantissa.
	logic [61:0] log_sq;
	logic [31:0] log_y;
	assign log_sq = 62'(x_q) * 62'(x_q);
	assign log_y  = log_sq[61:30];

	// Exp2 factor step.
	logic [63:0] exp_prod;
	logic [31:0] exp_next;
	assign exp_prod = 64'(m_q) * 64'(EXP_TAB[itc_q[3:0]]);
	assign exp_next = 32'((exp_prod + (64'd1 << 29)) >> 30);

	// Exponent arithmetic.
	logic signed [21:0] log_val;
	logic signed [38:0] lk_prod;
	logic [38:0]        t_mag;
	logic signed [27:0] e_val;
	logic signed [11:0] e_int;
	assign log_val = $signed({6'({1'b0, p_q} - 6'd16), frac_q});
	assign lk_prod = log_val * $signed({1'b0, inv_exponent_q});
	assign t_mag   = t_q[38] ? 39'(-t_q) : 39'(t_q);
	assign e_val   = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
	assign e_int   = 12'(e_val >>> 16);

	// Final scaling by 2^n with rounding.
	logic [5:0]  sh_amt;
	logic [47:0] sh_rnd;
	logic [32:0] sh_up;
	logic [31:0] s_scaled;
	assign sh_amt = 6'(7'sd14 - n_q);
	assign sh_rnd = 48'(m_q) + (48'd1 << (sh_amt - 6'd1));
	assign sh_up  = {m_q, 1'b0};
	always_comb begin
		if (n_q == 7'sd14)
			s_scaled = m_q;
		else if (n_q > 7'sd14)
			s_scaled = sh_up[32] ? 32'hFFFF_FFFF : sh_up[31:0];
		else
			s_scaled = 32'(sh_rnd >> sh_amt);
	end

	// Squared-ratio rounding for the one-and-a-half fuzzifier.
	logic [64:0] sqr_rnd;
	assign sqr_rnd = (65'(mul_q) + 65'd32768) >> 16;

	// Denominator and rounded numerator of the membership division.
	logic [32:0] den;
	logic [33:0] num2;
	assign den  = 33'(s_q) + 33'd65536;
	assign num2 = (34'd1 << 32) + 34'(den >> 1);

	// Clamped class count of a new pixel, as the index of its last class.
	logic [CW-1:0] last_idx_new;
	always_comb begin
		if (classes_in_use_q == 3'd0)
			last_idx_new = '0;
		else if (32'(classes_in_use_q) > CLASSES)
			last_idx_new = CW'(CLASSES - 1);
		else
			last_idx_new = CW'(classes_in_use_q - 3'd1);
	end

	logic [15:0] u_sat;
	assign u_sat = qt_q[16] ? 16'hFFFF : qt_q[15:0];

	// ---------------------------------------------------------------------
	// Next-state logic.
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (req_xfer && req.op == OP_CLASSIFY) state_d = ST_READ;
			ST_READ:     state_d = ST_SQA;
			ST_SQA:      state_d = ST_SQB;
			ST_SQB:      state_d = ST_DIVR_SET;
			ST_DIVR_SET: state_d = r_sat ? ST_POW : ST_DIVR;
			ST_DIVR:     if (itc_q == 5'd0) state_d = ST_POW;
			ST_POW: begin
				if (fuzz_mode_q == MODE_FUZZ_TWO)
					state_d = ST_DEN;
				else if (fuzz_mode_q == MODE_FUZZ_ONEHALF)
					state_d = ST_SQR;
				else if (r_q == 32'd0)
					state_d = ST_DEN;
				else
					state_d = ST_NORM;
			end
			ST_SQR:      state_d = ST_SQR_RND;
			ST_SQR_RND:  state_d = ST_DEN;
			ST_NORM:     if (nrm_q[31]) state_d = ST_LOG;
			ST_LOG:      if (itc_q == 5'd0) state_d = ST_LMUL;
			ST_LMUL:     state_d = ST_EABS;
			ST_EABS:     state_d = ST_EDEC;
			ST_EDEC: begin
				if (e_int >= 12'sd16 || e_int < -12'sd32)
					state_d = ST_DEN;
				else
					state_d = ST_EXP;
			end
			ST_EXP:      if (itc_q == 5'd0) state_d = ST_ESHIFT;
			ST_ESHIFT:   state_d = ST_DEN;
			ST_DEN:      state_d = ST_DIVU;
			ST_DIVU:     if (itc_q == 5'd0) state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free)
					state_d = (cls_q == last_idx_q) ? ST_IDLE : ST_READ;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Control registers.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			classes_in_use_q <= 3'd4;
			fuzz_mode_q      <= MODE_FUZZ_TWO;
			inv_exponent_q   <= 16'd4096;
			vld_q            <= '0;
			out_vld_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLASSES_IN_USE: classes_in_use_q <= cfg_data[2:0];
					CFG_FUZZ_MODE:      fuzz_mode_q      <= cfg_data[1:0];
					CFG_INV_EXPONENT:   inv_exponent_q   <= cfg_data;
					default: ;
				endcase
			end
			if (req_xfer && req.op == OP_LOAD && 32'(req.class_index) < CLASSES)
				vld_q[CW'(req.class_index)] <= 1'b1;
			if (state_q == ST_EMIT && out_free)
				out_vld_q <= 1'b1;
			else if (rsp_ready)
				out_vld_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Class table: written by loads, read into a register ahead of use.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_xfer && req.op == OP_LOAD && 32'(req.class_index) < CLASSES)
			mem[CW'(req.class_index)] <= {req.eta_value, req.center_ch1[SB-1:0],
				req.center_ch0[SB-1:0]};
		rd_q     <= mem[cls_q];
		rd_vld_q <= vld_q[cls_q];
	end

	// ---------------------------------------------------------------------
	// Datapath.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cls_q      <= '0;
				last_idx_q <= last_idx_new;
				px0_q      <= req.pixel_ch0[SB-1:0];
				px1_q      <= req.pixel_ch1[SB-1:0];
			end
			ST_SQA: a2_q <= sq_a[2*SB-1:0];
			ST_SQB: d2_q <= {1'b0, a2_q} + {1'b0, sq_b[2*SB-1:0]};
			ST_DIVR_SET: begin
				r_q   <= 32'hFFFF_FFFF;
				rem_q <= 33'(d2_q >> 16);
				dvd_q <= {d2_q[15:0], 16'd0};
				dvs_q <= {1'b0, eta_eff};
				qt_q  <= '0;
				itc_q <= 5'd31;
			end
			ST_DIVR, ST_DIVU: begin
				rem_q <= div_rem;
				dvd_q <= {dvd_q[30:0], 1'b0};
				qt_q  <= {qt_q[30:0], div_ge};
				itc_q <= itc_q - 5'd1;
				if (state_q == ST_DIVR && itc_q == 5'd0)
					r_q <= {qt_q[30:0], div_ge};
			end
			ST_POW: begin
				s_q   <= (fuzz_mode_q == MODE_FUZZ_TWO) ? r_q : 32'd0;
				nrm_q <= r_q;
				p_q   <= 5'd31;
			end
			ST_SQR:     mul_q <= 64'(r_q) * 64'(r_q);
			ST_SQR_RND: s_q   <= (sqr_rnd[64:32] != '0) ? 32'hFFFF_FFFF : sqr_rnd[31:0];
			ST_NORM: begin
				if (nrm_q[31]) begin
					x_q    <= nrm_q[31:1];
					frac_q <= '0;
					itc_q  <= 5'd15;
				end else begin
					nrm_q <= {nrm_q[30:0], 1'b0};
					p_q   <= p_q - 5'd1;
				end
			end
			ST_LOG: begin
				x_q    <= log_y[31] ? log_y[31:1] : log_y[30:0];
				frac_q <= {frac_q[14:0], log_y[31]};
				itc_q  <= itc_q - 5'd1;
			end
			ST_LMUL: t_q <= lk_prod;
			ST_EABS: begin
				neg_q <= t_q[38];
				q_q   <= 27'((t_mag + 39'd2048) >> 12);
			end
			ST_EDEC: begin
				s_q   <= (e_int >= 12'sd16) ? 32'hFFFF_FFFF : 32'd0;
				n_q   <= 7'(e_int);
				f_q   <= e_val[15:0];
				m_q   <= 32'd1 << 30;
				itc_q <= 5'd15;
			end
			ST_EXP: begin
				if (f_q[itc_q[3:0]])
					m_q <= exp_next;
				itc_q <= itc_q - 5'd1;
			end
			ST_ESHIFT: s_q <= s_scaled;
			ST_DEN: begin
				rem_q <= 33'(num2 >> 17);
				dvd_q <= {num2[16:0], 15'd0};
				dvs_q <= den;
				qt_q  <= '0;
				itc_q <= 5'd16;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q.result_class <= 2'(cls_q);
					out_q.membership   <= u_sat;
					out_q.last_class   <= (cls_q == last_idx_q);
					cls_q              <= cls_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/pm_checker.sv =====
// ----------------------------------------------------------------------------
// pm_checker
// Port-level checks of the possibilistic membership block, bound to the top.
// ----------------------------------------------------------------------------
module pm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         req_valid,
	input logic         req_ready,
	input pm_pkg::req_t req,
	input logic         rsp_valid,
	input logic         rsp_ready,
	input pm_pkg::rsp_t rsp
);
	import pm_pkg::*;

	// Class expected on the next result transfer.
	logic [1:0] exp_cls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cls_q <= 2'd0;
		end else if (rsp_valid && rsp_ready) begin
			exp_cls_q <= rsp.last_class ? 2'd0 : rsp.result_class + 2'd1;
		end
	end

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	else $error("result changed while stalled");

	// Results of a pixel come out in class order starting at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |-> rsp.result_class == exp_cls_q)
	else $error("result class out of order");

	// While a pixel still owes results, no new item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_class |-> !req_ready)
	else $error("item taken in the middle of a pixel");

	// No item is taken right after a result transfer that is not the last of its pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last_class |=> !(req_valid && req_ready))
	else $error("item taken before the last class of a pixel");

endmodule

bind possibilistic_membership pm_checker u_pm_checker (.*);
